### sv/lat_hist_pkg.sv
// ============================================================================
// Latency histogram package
// Shared types and constants for the latency histogram and percentile unit.
// ============================================================================
package lat_hist_pkg;

    localparam int unsigned NUM_BUCKETS_DEF  = 1024;
    localparam int unsigned BUCKET_WIDTH_DEF = 100;
    localparam logic [31:0] ALL_ONES32       = 32'hFFFF_FFFF;
    localparam int unsigned Q16_SHIFT        = 16;

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_REC_RD,
        ST_REC_WR,
        ST_Q_TGT,
        ST_Q_WALK,
        ST_Q_DONE
    } state_t;

endpackage

### sv/latency_histogram_percentile_unit.sv
// ============================================================================
// Latency histogram with percentile query
// Records latency samples into a bucket memory with running statistics and
// answers percentile queries by walking the bucket counts.
// ============================================================================
// Usage:
//   Request channel (req_valid / req_stall): op selects a record (sample_us)
//   or a percentile query (percent_q16, Q16 fraction). A request is taken at
//   a clock edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall): one response per request, in
//   order, carrying the bucket start for queries (0 for records) and the
//   count, sum, max and min as they stand after the request.
//   Steps: a record passes through a read step and a write step (ST_REC_RD,
//   ST_REC_WR); a new request can be taken in the write step, so records are
//   bound by the one read-modify-write of the bucket memory (read, then write).
//   A query computes its target (ST_Q_TGT) and then walks at most NUM_BUCKETS
//   buckets (ST_Q_WALK); the walk reads one bucket per cycle.
//   Reset: statistics go to their empty values at once; the bucket memory is
//   then cleared one entry per cycle, all NUM_BUCKETS entries, with req_stall high.
//   Back pressure: a finished response waits in the output register while the
//   next request is already taken; the block holds its last step until the
//   output register frees up.
// ============================================================================
module latency_histogram_percentile_unit #(
    parameter int unsigned NUM_BUCKETS     = lat_hist_pkg::NUM_BUCKETS_DEF,
    parameter int unsigned BUCKET_WIDTH_US = lat_hist_pkg::BUCKET_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  lat_hist_pkg::op_t  op,
    input  logic [31:0]        sample_us,
    input  logic [16:0]        percent_q16,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [31:0]        percentile_us,
    output logic [31:0]        sample_total,
    output logic [63:0]        latency_sum,
    output logic [31:0]        latency_max,
    output logic [31:0]        latency_min
);
    import lat_hist_pkg::*;

    // Index and counter widths
    localparam int unsigned IDX_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned CNT_W   = $clog2(NUM_BUCKETS + 1);
    localparam int unsigned ACC_W   = 32 + IDX_W;
    localparam int unsigned TGT_W   = 17 + 32 - Q16_SHIFT;
    localparam int unsigned BW_W    = $clog2(BUCKET_WIDTH_US + 1);
    localparam int unsigned START_W = CNT_W + BW_W;

    // Bucket index by reciprocal multiply: floor(s * m / 2^(32+l)) equals
    // floor(s / width) for every 32-bit s, with m = ceil(2^(32+l) / width).
    localparam int unsigned DIV_L     = $clog2(BUCKET_WIDTH_US);
    localparam int unsigned DIV_SHIFT = 32 + DIV_L;
    localparam logic [63:0] DIV_POW   = 64'd1 << DIV_SHIFT;
    localparam logic [32:0] DIV_MUL   =
        33'((DIV_POW + 64'(BUCKET_WIDTH_US) - 64'd1) / 64'(BUCKET_WIDTH_US));

    localparam logic [31:0]      LAST_IDX32 = 32'(NUM_BUCKETS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [CNT_W-1:0] NUM_CNT    = CNT_W'(NUM_BUCKETS);

    // ------------------------------------------------------------------
    // Bucket memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [31:0]      bucket_mem [NUM_BUCKETS];
    logic [31:0]      rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bucket_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= bucket_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [31:0]       quot_reg;
    logic [31:0]       sample_reg;
    logic [16:0]       pct_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  walk_reg;

    logic [31:0]       count_reg, count_next;
    logic [63:0]       sum_reg, sum_next;
    logic [31:0]       max_reg, max_next;
    logic [31:0]       min_reg, min_next;

    logic              rsp_valid_reg;
    logic [31:0]       rsp_pct_reg;
    logic [31:0]       rsp_count_reg;
    logic [63:0]       rsp_sum_reg;
    logic [31:0]       rsp_max_reg;
    logic [31:0]       rsp_min_reg;

    // Combinational helpers
    logic              accept;
    logic              out_free;
    logic              rsp_load;
    logic              rec_commit;
    logic              clr_done;
    logic [64:0]       div_prod;
    logic [31:0]       quot;
    logic [IDX_W-1:0]  rec_idx;
    logic [31:0]       bucket_inc;
    logic [48:0]       tgt_prod;
    logic              walk_go;
    logic [CNT_W-1:0]  walk_inc;
    logic              walk_rd;
    logic [CNT_W-1:0]  walk_fin;
    logic [START_W-1:0] start_us;
    logic [31:0]       start_sat;
    logic [31:0]       rsp_pct_val;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = req_valid && !req_stall;
    assign clr_done = (clr_idx_reg == LAST_IDX);

    // Bucket index: multiply and shift on the way in, clamp the registered quotient in the next cycle
    assign div_prod = 65'(sample_us) * 65'(DIV_MUL);
    assign quot     = 32'(div_prod >> DIV_SHIFT);
    assign rec_idx  = (quot_reg > LAST_IDX32) ? LAST_IDX : IDX_W'(quot_reg);

    assign bucket_inc = (rdata_reg == ALL_ONES32) ? rdata_reg : rdata_reg + 32'd1;

    // Record statistics, committed together with the bucket write
    assign count_next = (count_reg == ALL_ONES32) ? count_reg : count_reg + 32'd1;
    assign sum_next   = sum_reg + 64'(sample_reg);
    assign max_next   = (sample_reg > max_reg) ? sample_reg : max_reg;
    assign min_next   = (sample_reg < min_reg) ? sample_reg : min_reg;

    // Percentile target: floor(fraction * count), with the fraction in Q16
    assign tgt_prod = 49'(pct_reg) * 49'(count_reg);

    // Walk: rdata_reg holds the bucket at walk_reg while walking
    assign walk_go  = (walk_reg < NUM_CNT) && (acc_reg < ACC_W'(target_reg));
    assign walk_inc = walk_reg + CNT_W'(1);
    assign walk_rd  = walk_go && (walk_inc < NUM_CNT);
    assign walk_fin = (walk_reg == '0) ? '0 : walk_reg - CNT_W'(1);
    assign start_us = START_W'(walk_fin) * START_W'(BUCKET_WIDTH_US);
    assign start_sat = (64'(start_us) > 64'(ALL_ONES32)) ? ALL_ONES32 : 32'(start_us);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE, ST_REC_WR, ST_Q_DONE:
            begin
                if (accept)
                begin
                    state_next = (op == OP_RECORD) ? ST_REC_RD : ST_Q_TGT;
                end
                else if (state_reg != ST_IDLE && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REC_RD:
            begin
                state_next = ST_REC_WR;
            end
            ST_Q_TGT:
            begin
                state_next = ST_Q_WALK;
            end
            ST_Q_WALK:
            begin
                if (!walk_go)
                begin
                    state_next = ST_Q_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_stall  = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = bucket_inc;
        mem_re     = 1'b0;
        mem_raddr  = rec_idx;
        rsp_load   = 1'b0;
        rec_commit = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_REC_RD:
            begin
                mem_re = 1'b1;
            end
            ST_REC_WR:
            begin
                // finish only when the output register can take the response
                req_stall  = !out_free;
                mem_we     = out_free;
                rsp_load   = out_free;
                rec_commit = out_free;
            end
            ST_Q_TGT:
            begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            ST_Q_WALK:
            begin
                mem_re    = walk_rd;
                mem_raddr = IDX_W'(walk_inc);
            end
            ST_Q_DONE:
            begin
                req_stall = !out_free;
                rsp_load  = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_pct_val = (state_reg == ST_Q_DONE) ? start_sat : '0;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= ALL_ONES32;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && !clr_done)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (rec_commit)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                max_reg   <= max_next;
                min_reg   <= min_next;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quot_reg   <= quot;
            sample_reg <= sample_us;
            pct_reg    <= percent_q16;
        end
        if (state_reg == ST_REC_RD)
        begin
            idx_reg <= rec_idx;
        end
        if (state_reg == ST_Q_TGT)
        begin
            target_reg <= tgt_prod[48:Q16_SHIFT];
            acc_reg    <= '0;
            walk_reg   <= '0;
        end
        else if (state_reg == ST_Q_WALK && walk_go)
        begin
            acc_reg  <= acc_reg + ACC_W'(rdata_reg);
            walk_reg <= walk_inc;
        end
        if (rsp_load)
        begin
            rsp_pct_reg   <= rsp_pct_val;
            rsp_count_reg <= rec_commit ? count_next : count_reg;
            rsp_sum_reg   <= rec_commit ? sum_next : sum_reg;
            rsp_max_reg   <= rec_commit ? max_next : max_reg;
            rsp_min_reg   <= rec_commit ? min_next : min_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign percentile_us = rsp_pct_reg;
    assign sample_total  = rsp_count_reg;
    assign latency_sum   = rsp_sum_reg;
    assign latency_max   = rsp_max_reg;
    assign latency_min   = rsp_min_reg;

endmodule

### sv/lat_hist_checker.sv
// ============================================================================
// Latency histogram port checker
// Watches the ports of the latency histogram unit and flags broken behavior.
// ============================================================================
module lat_hist_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [31:0]        percentile_us,
    input  logic [31:0]        sample_total,
    input  logic [63:0]        latency_sum,
    input  logic [31:0]        latency_max,
    input  logic [31:0]        latency_min
);
    import lat_hist_pkg::*;

    logic [1:0]  outst_reg;
    logic [31:0] last_total_reg;
    logic        seen_reg;
    logic        req_take;
    logic        rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // Track requests taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg      <= '0;
            last_total_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            if (req_take && !rsp_take)
            begin
                outst_reg <= outst_reg + 2'd1;
            end
            else if (!req_take && rsp_take)
            begin
                outst_reg <= outst_reg - 2'd1;
            end
            if (rsp_take)
            begin
                last_total_reg <= sample_total;
                seen_reg       <= 1'b1;
            end
        end
    end

    // Hold a stalled response
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(percentile_us)
            && $stable(sample_total) && $stable(latency_sum)
            && $stable(latency_max) && $stable(latency_min)))
    else $error("stalled response changed");

    // Every response answers a request taken earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (outst_reg != 2'd0))
    else $error("response without a pending request");

    // Empty statistics until the first sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && sample_total == 32'd0) |->
            (latency_max == 32'd0 && latency_min == ALL_ONES32 && latency_sum == 64'd0))
    else $error("statistics not empty with zero samples");

    // Smallest sample never exceeds the largest
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && sample_total != 32'd0) |-> (latency_min <= latency_max))
    else $error("minimum above maximum");

    // Sample count never goes backward
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_take && seen_reg) |-> (sample_total >= last_total_reg))
    else $error("sample count decreased");

endmodule

bind latency_histogram_percentile_unit lat_hist_checker u_lat_hist_checker (.*);
